// ===== hw/rtl/pcfd_pkg.sv =====
`timescale 1ns / 1ps

package pcfd_pkg;

    // Widths of the interface fields
    localparam int EDGE_WIDTH    = 32;
    localparam int PERIOD_WIDTH  = 32;
    localparam int CLK_WIDTH     = 27;
    localparam int PRESC_WIDTH   = 11;
    localparam int DUTY_WIDTH    = 7;
    localparam int PROD_WIDTH    = PRESC_WIDTH + PERIOD_WIDTH;

    // Timestamp counter width, default for the top level parameter
    localparam int TS_WIDTH      = 32;

    // Configuration port
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 32;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_CPU_CLOCK_HZ    = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_TIMER_PRESCALER = 2'd1;

    localparam logic [CLK_WIDTH-1:0]   CLK_RESET   = 27'd8000000;
    localparam logic [PRESC_WIDTH-1:0] PRESC_RESET = 11'd8;

    // Full scale of the duty result
    localparam logic [DUTY_WIDTH-1:0] DUTY_FULL = 7'd100;

endpackage

// ===== hw/rtl/pcfd_sub_unit.sv =====
`timescale 1ns / 1ps

// Shared subtract and compare: diff = a - b, ge when a >= b.
module pcfd_sub_unit #(
    parameter int Width = 48
) (
    input  logic [Width-1:0] a,
    input  logic [Width-1:0] b,
    output logic             ge,
    output logic [Width-1:0] diff
);

    logic [Width:0] full;

    assign full = {1'b0, a} - {1'b0, b};
    assign ge   = ~full[Width];
    assign diff = full[Width-1:0];

endmodule

// ===== hw/rtl/pcfd_edge_tracker.sv =====
`timescale 1ns / 1ps

// Edge phase sequencer: first rising, then alternating falling and rising.
module pcfd_edge_tracker #(
    parameter int TsWidth = pcfd_pkg::TS_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               take,
    input  logic [TsWidth-1:0] t,
    output logic               close,
    output logic [TsWidth-1:0] period,
    output logic [TsWidth-1:0] high
);

    localparam logic [1:0] PHASE_FIRST = 2'd0;
    localparam logic [1:0] PHASE_FALL  = 2'd1;
    localparam logic [1:0] PHASE_RISE  = 2'd2;

    logic [1:0]         phase_reg, phase_next;
    logic [TsWidth-1:0] rise_reg, rise_next;
    logic [TsWidth-1:0] fall_reg, fall_next;

    assign close  = take && (phase_reg == PHASE_RISE);
    assign period = t - rise_reg;
    assign high   = fall_reg - rise_reg;

    always_comb begin
        phase_next = phase_reg;
        rise_next  = rise_reg;
        fall_next  = fall_reg;
        if (take) begin
            unique case (phase_reg)
                PHASE_FALL: begin
                    fall_next  = t;
                    phase_next = PHASE_RISE;
                end
                PHASE_RISE: begin
                    rise_next  = t;
                    phase_next = PHASE_FALL;
                end
                default: begin
                    // first edge, and the unused code: restart
                    rise_next  = t;
                    phase_next = PHASE_FALL;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_FIRST;
            rise_reg  <= '0;
            fall_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            rise_reg  <= rise_next;
            fall_reg  <= fall_next;
        end
    end

endmodule

// ===== hw/rtl/pwm_capture_freq_duty.sv =====
`timescale 1ns / 1ps
// Sequence: a closing rising edge is taken in idle, then ST_MUL, ST_FDIV, ST_DDIV and
//   ST_DONE lead to the output register; falling and opening edges give no result.
// Throughput: no new edge is taken until the sequencer is back in idle; the shared subtractor
//   runs 27 + 7 division steps per closing edge, and a stalled result channel holds ST_DONE.
// Reset (aresetn, synchronous, active low): edge phase back to the first rising edge,
//   stored timestamps zero, registers to 8000000 Hz and prescaler 8, no result pending.

module pwm_capture_freq_duty #(
    parameter int TimestampWidth = pcfd_pkg::TS_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcfd_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [pcfd_pkg::CFG_DATA_WIDTH-1:0] cfg_data,

    // edge input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pcfd_pkg::EDGE_WIDTH-1:0]     s_edge_time,

    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pcfd_pkg::PERIOD_WIDTH-1:0]   m_period_ticks,
    output logic [pcfd_pkg::PERIOD_WIDTH-1:0]   m_high_ticks,
    output logic [pcfd_pkg::CLK_WIDTH-1:0]      m_frequency_hz,
    output logic [pcfd_pkg::DUTY_WIDTH-1:0]     m_duty_percent,
    output logic                                m_zero_period
);

    localparam int CW  = pcfd_pkg::CLK_WIDTH;
    localparam int DW  = pcfd_pkg::DUTY_WIDTH;
    localparam int PW  = pcfd_pkg::PERIOD_WIDTH;
    localparam int PRW = pcfd_pkg::PROD_WIDTH;
    localparam int XW  = (TimestampWidth > PW) ? TimestampWidth : PW;
    // shared unit width: covers 100 * high and the 43-bit frequency divisor
    localparam int UW  = (TimestampWidth + DW > pcfd_pkg::PROD_WIDTH) ?
                         (TimestampWidth + DW) : pcfd_pkg::PROD_WIDTH;
    localparam int CNW = $clog2(CW);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_FDIV = 3'd2;
    localparam logic [2:0] ST_DDIV = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    // ------------------------------------------------------------------
    // Configuration registers; the port never stalls.
    // ------------------------------------------------------------------
    logic [CW-1:0]                   clk_hz_reg;
    logic [pcfd_pkg::PRESC_WIDTH-1:0] presc_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_hz_reg <= pcfd_pkg::CLK_RESET;
            presc_reg  <= pcfd_pkg::PRESC_RESET;
        end else if (cfg_valid) begin
            // drop writes to indexes beyond the register list
            if (cfg_index == pcfd_pkg::CFG_CPU_CLOCK_HZ) begin
                clk_hz_reg <= cfg_data[CW-1:0];
            end else if (cfg_index == pcfd_pkg::CFG_TIMER_PRESCALER) begin
                presc_reg <= cfg_data[pcfd_pkg::PRESC_WIDTH-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Edge phase tracking
    // ------------------------------------------------------------------
    logic [2:0]                state_reg, state_next;
    logic                      in_xfer;
    logic [XW-1:0]             edge_ext;
    logic [TimestampWidth-1:0] edge_ts;
    logic                      close;
    logic [TimestampWidth-1:0] period_w, high_w;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign edge_ext = XW'(s_edge_time);
    assign edge_ts  = edge_ext[TimestampWidth-1:0];

    pcfd_edge_tracker #(
        .TsWidth (TimestampWidth)
    ) u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (in_xfer),
        .t       (edge_ts),
        .close   (close),
        .period  (period_w),
        .high    (high_w)
    );

    // ------------------------------------------------------------------
    // Measurement datapath around one shared subtractor
    // ------------------------------------------------------------------
    logic [TimestampWidth-1:0]        period_reg, high_reg;
    logic [XW-1:0]                    period_ext, high_ext;
    logic [pcfd_pkg::PROD_WIDTH-1:0]  prod_reg;
    logic [UW-1:0]                    num_reg;
    logic [CW-1:0]                    clk_sh_reg;
    logic [CW:0]                      rem_reg;
    logic [CW-1:0]                    freq_q_reg;
    logic [DW-1:0]                    duty_q_reg;
    logic [CNW-1:0]                   cnt_reg;
    logic                             zero_reg, sat_reg, freq_ok_reg;

    logic [UW-1:0] su_a, su_b, su_diff;
    logic          su_ge;

    assign period_ext = XW'(period_reg);
    assign high_ext   = XW'(high_reg);

    always_comb begin
        unique case (state_reg)
            ST_MUL: begin
                // high against period: saturation check
                su_a = UW'(high_reg);
                su_b = UW'(period_reg);
            end
            ST_FDIV: begin
                su_a = UW'({rem_reg, clk_sh_reg[CW-1]});
                su_b = UW'(prod_reg);
            end
            ST_DDIV: begin
                su_a = num_reg;
                su_b = UW'(period_reg) << cnt_reg;
            end
            default: begin
                su_a = '0;
                su_b = '0;
            end
        endcase
    end

    pcfd_sub_unit #(
        .Width (UW)
    ) u_sub (
        .a    (su_a),
        .b    (su_b),
        .ge   (su_ge),
        .diff (su_diff)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic out_load;

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer && close) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_FDIV;
            end
            ST_FDIV: begin
                if (cnt_reg == '0) begin
                    state_next = ST_DDIV;
                end
            end
            ST_DDIV: begin
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer && close) begin
                    period_reg <= period_w;
                    high_reg   <= high_w;
                end
            end
            ST_MUL: begin
                prod_reg    <= PRW'(presc_reg) * PRW'(period_ext[PW-1:0]);
                num_reg     <= (UW'(high_reg) << 6) + (UW'(high_reg) << 5)
                             + (UW'(high_reg) << 2);
                zero_reg    <= (period_reg == '0);
                sat_reg     <= su_ge;
                freq_ok_reg <= (presc_reg != '0) && ((period_ext >> PW) == '0);
                clk_sh_reg  <= clk_hz_reg;
                rem_reg     <= '0;
                cnt_reg     <= CNW'(CW - 1);
            end
            ST_FDIV: begin
                // one restoring step of clock / (prescaler * period)
                rem_reg    <= su_ge ? su_diff[CW:0] : su_a[CW:0];
                freq_q_reg <= {freq_q_reg[CW-2:0], su_ge};
                clk_sh_reg <= clk_sh_reg << 1;
                if (cnt_reg == '0) begin
                    cnt_reg <= CNW'(DW - 1);
                end else begin
                    cnt_reg <= cnt_reg - CNW'(1);
                end
            end
            ST_DDIV: begin
                // one quotient bit of 100 * high / period
                if (su_ge) begin
                    num_reg <= su_diff;
                end
                duty_q_reg <= {duty_q_reg[DW-2:0], su_ge};
                cnt_reg    <= cnt_reg - CNW'(1);
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                m_valid_reg;
    logic [PW-1:0]       m_period_reg, m_high_reg;
    logic [CW-1:0]       m_freq_reg;
    logic [DW-1:0]       m_duty_reg;
    logic                m_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_period_reg <= period_ext[PW-1:0];
            m_high_reg   <= high_ext[PW-1:0];
            m_zero_reg   <= zero_reg;
            if (zero_reg) begin
                m_freq_reg <= '0;
                m_duty_reg <= '0;
            end else begin
                m_freq_reg <= freq_ok_reg ? freq_q_reg : '0;
                m_duty_reg <= sat_reg ? pcfd_pkg::DUTY_FULL : duty_q_reg;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_period_ticks = m_period_reg;
    assign m_high_ticks   = m_high_reg;
    assign m_frequency_hz = m_freq_reg;
    assign m_duty_percent = m_duty_reg;
    assign m_zero_period  = m_zero_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_close_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && close) |=> (state_reg == ST_MUL))
        else $error("closing edge did not start a measurement");

    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result presented without a finished measurement");

    a_zero_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_period) |-> (m_frequency_hz == '0 && m_duty_percent == '0))
        else $error("zero period with nonzero frequency or duty");

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_duty_percent <= pcfd_pkg::DUTY_FULL))
        else $error("duty above full scale");

endmodule
